/* rtl/cpb_pkg.sv */
`timescale 1ns / 1ps

package cpb_pkg;

  localparam int CRD_W     = 32;
  localparam int NRM_W     = 16;
  localparam int AREA_W    = 69;
  localparam int SUM_W     = 101;
  localparam int NUM_W     = 102;
  localparam int DEN_W     = 72;
  localparam int AD3_W     = 71;
  localparam int Q_W       = 32;
  localparam int Q_CNT_W   = 6;
  localparam int SQ_IN_W   = 31;
  localparam int SQ_RES_W  = 16;
  localparam int NRM_SHIFT = 30;

  localparam logic [31:0] EPS_RESET = 32'd4295;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_COUNT  = 3'd1,
    ST_ZERO_AREA  = 3'd2,
    ST_SHORT_EDGE = 3'd3,
    ST_NOT_CONVEX = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_STORE,
    OP_CLEAR,
    OP_FETCH2,
    OP_FETCH_C,
    OP_XMUL,
    OP_XSUB,
    OP_SMUL,
    OP_SACC,
    OP_EDGE_SQ,
    OP_EDGE_SUM,
    OP_DIV_NX,
    OP_DIV_NY,
    OP_SQRT,
    OP_NORM_WR_X,
    OP_NORM_WR_Y,
    OP_CVX_MUL,
    OP_CVX_SUB,
    OP_ABS,
    OP_AD3,
    OP_NUM,
    OP_DIV_CX,
    OP_DIV_CY,
    OP_CEN_X,
    OP_CEN_Y,
    OP_EMIT,
    OP_EMIT_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    status_t     code;
    logic [2:0]  corner_index;
    logic [3:0]  corner_count;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic area_small;
    logic area_neg;
    logic edge_short;
    logic not_convex;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } stat_t;

endpackage

/* rtl/cpb_div.sv */
`timescale 1ns / 1ps

module cpb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cpb_pkg::NUM_W-1:0]  num,
  input  logic [cpb_pkg::DEN_W-1:0]  den,
  output logic                       busy,
  output logic [cpb_pkg::Q_W-1:0]    quot
);

  logic [cpb_pkg::DEN_W-1:0]   rem_r;
  logic [cpb_pkg::DEN_W-1:0]   den_r;
  logic [cpb_pkg::Q_W-1:0]     low_r;
  logic [cpb_pkg::Q_W-1:0]     quo_r;
  logic [cpb_pkg::Q_CNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic [cpb_pkg::DEN_W:0]     trial;
  logic [cpb_pkg::DEN_W:0]     diff;
  logic                        take;

  assign trial = {rem_r, low_r[cpb_pkg::Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= cpb_pkg::Q_CNT_W'(cpb_pkg::Q_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - cpb_pkg::Q_CNT_W'(1);
      if (cnt_r == cpb_pkg::Q_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= cpb_pkg::DEN_W'(num >> cpb_pkg::Q_W);
      low_r <= num[cpb_pkg::Q_W-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[cpb_pkg::DEN_W-1:0] : trial[cpb_pkg::DEN_W-1:0];
      low_r <= {low_r[cpb_pkg::Q_W-2:0], 1'b0};
      quo_r <= {quo_r[cpb_pkg::Q_W-2:0], take};
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

/* rtl/cpb_isqrt.sv */
`timescale 1ns / 1ps

module cpb_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cpb_pkg::SQ_IN_W-1:0]   val,
  output logic                          busy,
  output logic [cpb_pkg::SQ_RES_W-1:0]  res
);

  logic [cpb_pkg::SQ_IN_W-1:0] v_r;
  logic [cpb_pkg::SQ_IN_W:0]   res_r;
  logic [cpb_pkg::SQ_IN_W-1:0] bit_r;
  logic                        busy_r;
  logic [cpb_pkg::SQ_IN_W:0]   sum;
  logic                        fits;

  assign sum  = res_r + {1'b0, bit_r};
  assign fits = {1'b0, v_r} >= sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (bit_r[1:0] != 2'b00)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= val;
      res_r <= '0;
      bit_r <= {1'b1, {(cpb_pkg::SQ_IN_W-1){1'b0}}};
    end else if (busy_r) begin
      if (fits) begin
        v_r   <= v_r - sum[cpb_pkg::SQ_IN_W-1:0];
        res_r <= (res_r >> 1) + {1'b0, bit_r};
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign res  = res_r[cpb_pkg::SQ_RES_W-1:0];

endmodule

/* rtl/cpb_dp.sv */
`timescale 1ns / 1ps

module cpb_dp #(
  parameter int MAX_CORNERS = 8,
  localparam int AW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cpb_pkg::cmd_t         cmd,
  input  logic [AW-1:0]         addr0,
  input  logic [AW-1:0]         addr1,
  input  logic signed [31:0]    in_x,
  input  logic signed [31:0]    in_y,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_data,
  input  logic                  out_ready,
  output cpb_pkg::stat_t        stat,
  output logic                  out_valid,
  output cpb_pkg::status_t      out_status,
  output logic [2:0]            out_index,
  output logic signed [31:0]    out_x,
  output logic signed [31:0]    out_y,
  output logic signed [15:0]    out_nx,
  output logic signed [15:0]    out_ny,
  output logic signed [31:0]    out_cx,
  output logic signed [31:0]    out_cy,
  output logic [3:0]            out_count,
  output logic                  out_last
);

  localparam int AREA_W = cpb_pkg::AREA_W;
  localparam int SUM_W  = cpb_pkg::SUM_W;
  localparam int NUM_W  = cpb_pkg::NUM_W;
  localparam int DEN_W  = cpb_pkg::DEN_W;
  localparam int AD3_W  = cpb_pkg::AD3_W;

  logic [63:0]                store_mem [MAX_CORNERS];
  logic signed [15:0]         nx_mem [MAX_CORNERS];
  logic signed [15:0]         ny_mem [MAX_CORNERS];

  logic [31:0]                eps_r;
  logic [63:0]                eps_sq_r;
  logic signed [31:0]         pa_x_r, pa_y_r, pb_x_r, pb_y_r, pc_x_r, pc_y_r;
  logic signed [63:0]         m1_r, m2_r;
  logic signed [64:0]         cr_r;
  logic signed [AREA_W-1:0]   area_r;
  logic signed [65:0]         phx_r, plx_r, phy_r, ply_r;
  logic signed [SUM_W-1:0]    sx_r, sy_r;
  logic [64:0]                sqx_r, sqy_r;
  logic [65:0]                lensq_r;
  logic                       negnx_r, negny_r;
  logic signed [65:0]         mc1_r, mc2_r;
  logic signed [66:0]         cv_r;
  logic [AREA_W-1:0]          absa_r;
  logic [SUM_W-1:0]           abssx_r, abssy_r;
  logic                       negx_r, negy_r;
  logic [AD3_W-1:0]           ad3_r;
  logic [NUM_W-1:0]           numx_r, numy_r;
  logic [DEN_W-1:0]           den_r;
  logic                       sat_r;
  logic signed [31:0]         cen_x_r, cen_y_r;
  logic                       out_valid_r;

  logic signed [32:0]         ex, ey, e2x, e2y, ssx, ssy, chi, clo;
  logic signed [65:0]         sqx_full, sqy_full;
  logic signed [AREA_W-1:0]   eps_a;
  logic signed [66:0]         eps_c;
  logic                       div_start, div_busy;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic [cpb_pkg::Q_W-1:0]    quot;
  logic                       sqrt_busy;
  logic [cpb_pkg::SQ_RES_W-1:0] sq_res;
  logic [15:0]                nmag;
  logic [32:0]                lim, qv;
  logic                       cen_neg;
  logic                       emit_any;

  assign ex  = 33'(pb_x_r) - 33'(pa_x_r);
  assign ey  = 33'(pb_y_r) - 33'(pa_y_r);
  assign e2x = 33'(pc_x_r) - 33'(pb_x_r);
  assign e2y = 33'(pc_y_r) - 33'(pb_y_r);
  assign ssx = 33'(pa_x_r) + 33'(pb_x_r);
  assign ssy = 33'(pa_y_r) + 33'(pb_y_r);
  assign chi = $signed(cr_r[64:32]);
  assign clo = $signed({1'b0, cr_r[31:0]});
  assign sqx_full = ex * ex;
  assign sqy_full = ey * ey;
  assign eps_a = AREA_W'(eps_r);
  assign eps_c = 67'(eps_r);

  assign nmag = 16'((17'(sq_res) + 17'd1) >> 1);

  assign cen_neg = (cmd.op == cpb_pkg::OP_CEN_X) ? negx_r : negy_r;
  assign lim     = cen_neg ? 33'h080000000 : 33'h07FFFFFFF;
  assign qv      = (sat_r || ({1'b0, quot} > lim)) ? lim : {1'b0, quot};

  assign div_start = (cmd.op == cpb_pkg::OP_DIV_NX) || (cmd.op == cpb_pkg::OP_DIV_NY) ||
                     (cmd.op == cpb_pkg::OP_DIV_CX) || (cmd.op == cpb_pkg::OP_DIV_CY);

  always_comb begin
    div_num = '0;
    div_den = den_r;
    case (cmd.op)
      cpb_pkg::OP_DIV_NX: begin
        div_num = NUM_W'({sqy_r, {cpb_pkg::NRM_SHIFT{1'b0}}});
        div_den = DEN_W'(lensq_r);
      end
      cpb_pkg::OP_DIV_NY: begin
        div_num = NUM_W'({sqx_r, {cpb_pkg::NRM_SHIFT{1'b0}}});
        div_den = DEN_W'(lensq_r);
      end
      cpb_pkg::OP_DIV_CX: div_num = numx_r;
      cpb_pkg::OP_DIV_CY: div_num = numy_r;
      default: div_num = '0;
    endcase
  end

  cpb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  cpb_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == cpb_pkg::OP_SQRT),
    .val   (quot[cpb_pkg::SQ_IN_W-1:0]),
    .busy  (sqrt_busy),
    .res   (sq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= cpb_pkg::EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cpb_pkg::OP_STORE) begin
      store_mem[addr0] <= {in_y, in_x};
    end
    if (cmd.op == cpb_pkg::OP_NORM_WR_X) begin
      nx_mem[addr0] <= negnx_r ? -nmag : nmag;
    end
    if (cmd.op == cpb_pkg::OP_NORM_WR_Y) begin
      ny_mem[addr0] <= negny_r ? -nmag : nmag;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      cpb_pkg::OP_CLEAR: begin
        area_r   <= '0;
        sx_r     <= '0;
        sy_r     <= '0;
        eps_sq_r <= eps_r * eps_r;
      end
      cpb_pkg::OP_FETCH2: begin
        {pa_y_r, pa_x_r} <= store_mem[addr0];
        {pb_y_r, pb_x_r} <= store_mem[addr1];
      end
      cpb_pkg::OP_FETCH_C: begin
        {pc_y_r, pc_x_r} <= store_mem[addr0];
      end
      cpb_pkg::OP_XMUL: begin
        m1_r <= pa_x_r * pb_y_r;
        m2_r <= pa_y_r * pb_x_r;
      end
      cpb_pkg::OP_XSUB: begin
        cr_r   <= 65'(m1_r) - 65'(m2_r);
        area_r <= area_r + AREA_W'(m1_r) - AREA_W'(m2_r);
      end
      cpb_pkg::OP_SMUL: begin
        phx_r <= ssx * chi;
        plx_r <= ssx * clo;
        phy_r <= ssy * chi;
        ply_r <= ssy * clo;
      end
      cpb_pkg::OP_SACC: begin
        sx_r <= sx_r + (SUM_W'(phx_r) <<< 32) + SUM_W'(plx_r);
        sy_r <= sy_r + (SUM_W'(phy_r) <<< 32) + SUM_W'(ply_r);
      end
      cpb_pkg::OP_EDGE_SQ: begin
        sqx_r   <= sqx_full[64:0];
        sqy_r   <= sqy_full[64:0];
        negnx_r <= ey < 0;
        negny_r <= ex > 0;
      end
      cpb_pkg::OP_EDGE_SUM: begin
        lensq_r <= 66'(sqx_r) + 66'(sqy_r);
      end
      cpb_pkg::OP_CVX_MUL: begin
        mc1_r <= ex * e2y;
        mc2_r <= ey * e2x;
      end
      cpb_pkg::OP_CVX_SUB: begin
        cv_r <= 67'(mc1_r) - 67'(mc2_r);
      end
      cpb_pkg::OP_ABS: begin
        absa_r  <= area_r[AREA_W-1] ? AREA_W'(-area_r) : AREA_W'(area_r);
        abssx_r <= sx_r[SUM_W-1] ? SUM_W'(-sx_r) : SUM_W'(sx_r);
        abssy_r <= sy_r[SUM_W-1] ? SUM_W'(-sy_r) : SUM_W'(sy_r);
        negx_r  <= sx_r[SUM_W-1] ^ area_r[AREA_W-1];
        negy_r  <= sy_r[SUM_W-1] ^ area_r[AREA_W-1];
      end
      cpb_pkg::OP_AD3: begin
        ad3_r <= AD3_W'(absa_r) + AD3_W'({absa_r, 1'b0});
      end
      cpb_pkg::OP_NUM: begin
        numx_r <= NUM_W'({abssx_r, 1'b0}) + NUM_W'(ad3_r);
        numy_r <= NUM_W'({abssy_r, 1'b0}) + NUM_W'(ad3_r);
        den_r  <= DEN_W'({ad3_r, 1'b0});
      end
      cpb_pkg::OP_DIV_CX: begin
        sat_r <= (numx_r >> cpb_pkg::Q_W) >= NUM_W'(den_r);
      end
      cpb_pkg::OP_DIV_CY: begin
        sat_r <= (numy_r >> cpb_pkg::Q_W) >= NUM_W'(den_r);
      end
      cpb_pkg::OP_CEN_X: begin
        cen_x_r <= 32'(cen_neg ? -qv : qv);
      end
      cpb_pkg::OP_CEN_Y: begin
        cen_y_r <= 32'(cen_neg ? -qv : qv);
      end
      default: begin
      end
    endcase
  end

  assign emit_any = (cmd.op == cpb_pkg::OP_EMIT) || (cmd.op == cpb_pkg::OP_EMIT_ERR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_any) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cpb_pkg::OP_EMIT) begin
      out_status     <= cpb_pkg::ST_OK;
      out_index      <= cmd.corner_index;
      {out_y, out_x} <= store_mem[addr0];
      out_nx         <= nx_mem[addr1];
      out_ny         <= ny_mem[addr1];
      out_cx         <= cen_x_r;
      out_cy         <= cen_y_r;
      out_count      <= cmd.corner_count;
      out_last       <= cmd.last;
    end else if (cmd.op == cpb_pkg::OP_EMIT_ERR) begin
      out_status <= cmd.code;
      out_index  <= '0;
      out_x      <= '0;
      out_y      <= '0;
      out_nx     <= '0;
      out_ny     <= '0;
      out_cx     <= '0;
      out_cy     <= '0;
      out_count  <= '0;
      out_last   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat.area_small = (area_r <= eps_a) && (area_r >= -eps_a);
    stat.area_neg   = area_r[AREA_W-1];
    stat.edge_short = (lensq_r[65:32] == '0) && ({lensq_r[31:0], 32'b0} <= eps_sq_r);
    stat.not_convex = cv_r <= eps_c;
    stat.div_busy   = div_busy;
    stat.sqrt_busy  = sqrt_busy;
    stat.out_free   = !out_valid_r || out_ready;
  end

endmodule

/* rtl/cpb_ctrl.sv */
`timescale 1ns / 1ps

module cpb_ctrl #(
  parameter int MAX_CORNERS = 8,
  localparam int AW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1,
  localparam int CW = $clog2(MAX_CORNERS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  cpb_pkg::stat_t  stat,
  output cpb_pkg::cmd_t   cmd,
  output logic [AW-1:0]   addr0,
  output logic [AW-1:0]   addr1
);

  typedef enum logic [5:0] {
    S_LOAD, S_CHECK,
    S_AF, S_AX, S_AS, S_AM, S_AA, S_ACHK,
    S_EF, S_ESQ, S_ESUM, S_ECHK,
    S_EXW, S_EXS, S_EXQ, S_EXN,
    S_EYD, S_EYW, S_EYS, S_EYQ, S_EYN,
    S_CF, S_CFC, S_CM, S_CS, S_CCHK,
    S_D1, S_D2, S_D3,
    S_DX, S_DXW, S_DXE, S_DY, S_DYW, S_DYE,
    S_OUT, S_ERR
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic               ov_r, ov_nxt;
  logic               rev_r, rev_nxt;
  cpb_pkg::status_t   code_r, code_nxt;

  logic               last_i, last_j;
  logic [AW-1:0]      j, k, pi, pj, pk;
  logic [AW-1:0]      i_inc;

  assign last_i = (CW'(i_r) == n_r - CW'(1));
  assign j      = last_i ? '0 : i_r + AW'(1);
  assign last_j = (CW'(j) == n_r - CW'(1));
  assign k      = last_j ? '0 : j + AW'(1);
  assign pi     = rev_r ? AW'(n_r - CW'(1) - CW'(i_r)) : i_r;
  assign pj     = rev_r ? AW'(n_r - CW'(1) - CW'(j)) : j;
  assign pk     = rev_r ? AW'(n_r - CW'(1) - CW'(k)) : k;
  assign i_inc  = i_r + AW'(1);

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    ov_nxt    = ov_r;
    rev_nxt   = rev_r;
    code_nxt  = code_r;
    cmd.op           = cpb_pkg::OP_NONE;
    cmd.code         = code_r;
    cmd.corner_index = 3'(i_r);
    cmd.corner_count = 4'(n_r);
    cmd.last         = last_i;
    addr0 = '0;
    addr1 = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (n_r < CW'(MAX_CORNERS)) begin
            cmd.op = cpb_pkg::OP_STORE;
            addr0  = AW'(n_r);
            n_nxt  = n_r + CW'(1);
          end else begin
            ov_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (ov_r || (n_r < CW'(3))) begin
          code_nxt  = cpb_pkg::ST_BAD_COUNT;
          state_nxt = S_ERR;
        end else begin
          cmd.op    = cpb_pkg::OP_CLEAR;
          i_nxt     = '0;
          rev_nxt   = 1'b0;
          state_nxt = S_AF;
        end
      end
      S_AF: begin
        cmd.op = cpb_pkg::OP_FETCH2;
        addr0  = i_r;
        addr1  = j;
        state_nxt = S_AX;
      end
      S_AX: begin
        cmd.op = cpb_pkg::OP_XMUL;
        state_nxt = S_AS;
      end
      S_AS: begin
        cmd.op = cpb_pkg::OP_XSUB;
        state_nxt = S_AM;
      end
      S_AM: begin
        cmd.op = cpb_pkg::OP_SMUL;
        state_nxt = S_AA;
      end
      S_AA: begin
        cmd.op = cpb_pkg::OP_SACC;
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = S_ACHK;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_AF;
        end
      end
      S_ACHK: begin
        if (stat.area_small) begin
          code_nxt  = cpb_pkg::ST_ZERO_AREA;
          state_nxt = S_ERR;
        end else begin
          rev_nxt   = stat.area_neg;
          state_nxt = S_EF;
        end
      end
      S_EF: begin
        cmd.op = cpb_pkg::OP_FETCH2;
        addr0  = pi;
        addr1  = pj;
        state_nxt = S_ESQ;
      end
      S_ESQ: begin
        cmd.op = cpb_pkg::OP_EDGE_SQ;
        state_nxt = S_ESUM;
      end
      S_ESUM: begin
        cmd.op = cpb_pkg::OP_EDGE_SUM;
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        if (stat.edge_short) begin
          code_nxt  = cpb_pkg::ST_SHORT_EDGE;
          state_nxt = S_ERR;
        end else begin
          cmd.op    = cpb_pkg::OP_DIV_NX;
          state_nxt = S_EXW;
        end
      end
      S_EXW: begin
        if (!stat.div_busy) begin
          state_nxt = S_EXS;
        end
      end
      S_EXS: begin
        cmd.op = cpb_pkg::OP_SQRT;
        state_nxt = S_EXQ;
      end
      S_EXQ: begin
        if (!stat.sqrt_busy) begin
          state_nxt = S_EXN;
        end
      end
      S_EXN: begin
        cmd.op = cpb_pkg::OP_NORM_WR_X;
        addr0  = i_r;
        state_nxt = S_EYD;
      end
      S_EYD: begin
        cmd.op = cpb_pkg::OP_DIV_NY;
        state_nxt = S_EYW;
      end
      S_EYW: begin
        if (!stat.div_busy) begin
          state_nxt = S_EYS;
        end
      end
      S_EYS: begin
        cmd.op = cpb_pkg::OP_SQRT;
        state_nxt = S_EYQ;
      end
      S_EYQ: begin
        if (!stat.sqrt_busy) begin
          state_nxt = S_EYN;
        end
      end
      S_EYN: begin
        cmd.op = cpb_pkg::OP_NORM_WR_Y;
        addr0  = i_r;
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = S_CF;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_EF;
        end
      end
      S_CF: begin
        cmd.op = cpb_pkg::OP_FETCH2;
        addr0  = pi;
        addr1  = pj;
        state_nxt = S_CFC;
      end
      S_CFC: begin
        cmd.op = cpb_pkg::OP_FETCH_C;
        addr0  = pk;
        state_nxt = S_CM;
      end
      S_CM: begin
        cmd.op = cpb_pkg::OP_CVX_MUL;
        state_nxt = S_CS;
      end
      S_CS: begin
        cmd.op = cpb_pkg::OP_CVX_SUB;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (stat.not_convex) begin
          code_nxt  = cpb_pkg::ST_NOT_CONVEX;
          state_nxt = S_ERR;
        end else if (last_i) begin
          i_nxt     = '0;
          state_nxt = S_D1;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_CF;
        end
      end
      S_D1: begin
        cmd.op = cpb_pkg::OP_ABS;
        state_nxt = S_D2;
      end
      S_D2: begin
        cmd.op = cpb_pkg::OP_AD3;
        state_nxt = S_D3;
      end
      S_D3: begin
        cmd.op = cpb_pkg::OP_NUM;
        state_nxt = S_DX;
      end
      S_DX: begin
        cmd.op = cpb_pkg::OP_DIV_CX;
        state_nxt = S_DXW;
      end
      S_DXW: begin
        if (!stat.div_busy) begin
          state_nxt = S_DXE;
        end
      end
      S_DXE: begin
        cmd.op = cpb_pkg::OP_CEN_X;
        state_nxt = S_DY;
      end
      S_DY: begin
        cmd.op = cpb_pkg::OP_DIV_CY;
        state_nxt = S_DYW;
      end
      S_DYW: begin
        if (!stat.div_busy) begin
          state_nxt = S_DYE;
        end
      end
      S_DYE: begin
        cmd.op = cpb_pkg::OP_CEN_Y;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op = cpb_pkg::OP_EMIT;
          addr0  = pi;
          addr1  = i_r;
          if (last_i) begin
            n_nxt     = '0;
            ov_nxt    = 1'b0;
            i_nxt     = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt = i_inc;
          end
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.op    = cpb_pkg::OP_EMIT_ERR;
          n_nxt     = '0;
          ov_nxt    = 1'b0;
          i_nxt     = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      i_r     <= '0;
      n_r     <= '0;
      ov_r    <= 1'b0;
      rev_r   <= 1'b0;
      code_r  <= cpb_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
      rev_r   <= rev_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

/* rtl/convex_polygon_builder_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Contents
// in_       slave      in_tvalid / in_tready     one vertex per request, tlast on the last
// out_      master     out_tvalid / out_tready   one result per corner, or one error status
// cfg_      slave      cfg_valid / cfg_ready     area_epsilon write, always ready
//
// Vertices load at one request per cycle. After the last vertex the polygon is
// evaluated; its run time is set mostly by the shared 32-step divider and
// 16-step square root that produce the two normal components per edge.
// Results then leave at one per cycle while out_tready is high; the next
// polygon may load while the last result is still held. Reset is synchronous.

module convex_polygon_builder_unit #(
  parameter int MAX_CORNERS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,   // point_x [31:0], point_y [63:32]
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [167:0]  out_tdata,  // corner_index, out_x, out_y, normal_x, normal_y,
                                    // center_x, center_y, corner_count, zero pad
  output logic [2:0]    out_tuser,  // status
  output logic          out_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  localparam int AW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;

  cpb_pkg::cmd_t     cmd;
  cpb_pkg::stat_t    stat;
  logic [AW-1:0]     addr0, addr1;
  cpb_pkg::status_t  out_status;
  logic [2:0]        out_index;
  logic signed [31:0] out_x, out_y, out_cx, out_cy;
  logic signed [15:0] out_nx, out_ny;
  logic [3:0]        out_count;

  assign cfg_ready = 1'b1;

  cpb_ctrl #(.MAX_CORNERS(MAX_CORNERS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd),
    .addr0    (addr0),
    .addr1    (addr1)
  );

  cpb_dp #(.MAX_CORNERS(MAX_CORNERS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .addr0      (addr0),
    .addr1      (addr1),
    .in_x       (in_tdata[31:0]),
    .in_y       (in_tdata[63:32]),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (out_tready),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_status (out_status),
    .out_index  (out_index),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_nx     (out_nx),
    .out_ny     (out_ny),
    .out_cx     (out_cx),
    .out_cy     (out_cy),
    .out_count  (out_count),
    .out_last   (out_tlast)
  );

  assign out_tuser = out_status;
  assign out_tdata = {1'b0, out_count, out_cy, out_cx, out_ny, out_nx, out_y, out_x, out_index};

endmodule

/* tb/tb_convex_polygon_builder_unit.sv */
`timescale 1ns / 1ps

module tb_convex_polygon_builder_unit;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    cpb_pkg::status_t status;
    logic [2:0]  corner_index;
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [3:0]  count;
    logic        last;
  } corner_res_t;

  localparam int NCORN = 8;
  localparam int SETTLE = 1500;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [63:0]   in_tdata = '0;
  logic          in_tlast = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [167:0]  out_tdata;
  logic [2:0]    out_tuser;
  logic          out_tlast;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [31:0]   cfg_data = '0;

  corner_res_t   polygon_q[$];
  logic signed [31:0] held_x[NCORN];
  logic signed [31:0] held_y[NCORN];
  int unsigned   held_n = 0;
  bit            held_over = 0;
  logic [31:0]   epsilon = cpb_pkg::EPS_RESET;
  bit            calm = 0;
  int            fails = 0;

  convex_polygon_builder_unit #(.MAX_CORNERS(NCORN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("convex_polygon_builder_unit verification failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 32;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_part(wide_t c, wide_t lensq);
    logic [127:0] m, q;
    logic [15:0] r;
    m = (c < 0) ? -c : c;
    q = ((m * m) << 30) / lensq;
    r = 16'((int_sqrt(q[63:0]) + 1) >> 1);
    return (c < 0) ? -r : r;
  endfunction

  function automatic logic [31:0] centroid_part(wide_t n, wide_t d);
    logic [127:0] an, ad, q, lim;
    bit neg;
    neg = (n < 0) ^ (d < 0);
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = ((an << 1) + ad) / (ad << 1);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic wide_t cross2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
    return ax * by - ay * bx;
  endfunction

  function automatic void push_error(cpb_pkg::status_t code);
    corner_res_t r;
    r = '{status: code, corner_index: 0, px: 0, py: 0, nx: 0, ny: 0,
          cx: 0, cy: 0, count: 0, last: 1'b1};
    polygon_q.push_back(r);
  endfunction

  function automatic void absorb_vertex(logic signed [31:0] x, logic signed [31:0] y, bit fin);
    wide_t vx[NCORN], vy[NCORN], tx, ty, eps, area, ex, ey, lensq, c, sx, sy, den;
    logic [15:0] nrx[NCORN], nry[NCORN];
    logic [31:0] cenx, ceny;
    int unsigned n, j, k;
    corner_res_t r;
    if (held_n < NCORN) begin
      held_x[held_n] = x;
      held_y[held_n] = y;
      held_n++;
    end else begin
      held_over = 1;
    end
    if (!fin) return;
    n = held_n;
    held_n = 0;
    if (held_over || n < 3) begin
      held_over = 0;
      push_error(cpb_pkg::ST_BAD_COUNT);
      return;
    end
    eps = {96'd0, epsilon};
    area = 0;
    for (int i = 0; i < n; i++) begin
      vx[i] = held_x[i];
      vy[i] = held_y[i];
    end
    for (int i = 0; i < n; i++) begin
      j = (i + 1) % n;
      area += cross2(vx[i], vy[i], vx[j], vy[j]);
    end
    if (!(eps < ((area < 0) ? -area : area))) begin
      push_error(cpb_pkg::ST_ZERO_AREA);
      return;
    end
    if (area < 0) begin
      for (int i = 0; i < n / 2; i++) begin
        tx = vx[i]; ty = vy[i];
        vx[i] = vx[n-1-i]; vy[i] = vy[n-1-i];
        vx[n-1-i] = tx; vy[n-1-i] = ty;
      end
      area = -area;
    end
    for (int i = 0; i < n; i++) begin
      j = (i + 1) % n;
      ex = vx[j] - vx[i];
      ey = vy[j] - vy[i];
      lensq = ex * ex + ey * ey;
      if (!($unsigned(eps * eps) < $unsigned(lensq << 32))) begin
        push_error(cpb_pkg::ST_SHORT_EDGE);
        return;
      end
      nrx[i] = unit_part(ey, lensq);
      nry[i] = unit_part(-ex, lensq);
    end
    for (int i = 0; i < n; i++) begin
      j = (i + 1) % n;
      k = (i + 2) % n;
      c = cross2(vx[j] - vx[i], vy[j] - vy[i], vx[k] - vx[j], vy[k] - vy[j]);
      if (!(eps < c)) begin
        push_error(cpb_pkg::ST_NOT_CONVEX);
        return;
      end
    end
    sx = 0;
    sy = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1) % n;
      c = cross2(vx[i], vy[i], vx[j], vy[j]);
      sx += (vx[i] + vx[j]) * c;
      sy += (vy[i] + vy[j]) * c;
    end
    den = area * 3;
    cenx = centroid_part(sx, den);
    ceny = centroid_part(sy, den);
    for (int i = 0; i < n; i++) begin
      r = '{status: cpb_pkg::ST_OK, corner_index: i[2:0], px: vx[i][31:0],
            py: vy[i][31:0], nx: nrx[i], ny: nry[i], cx: cenx, cy: ceny,
            count: n[3:0], last: (i + 1 == n)};
      polygon_q.push_back(r);
    end
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    corner_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (polygon_q.size() == 0) begin
        $error("result with no request pending");
        fails++;
      end else begin
        e = polygon_q.pop_front();
        check_field("status", e.status, out_tuser);
        check_field("corner_index", e.corner_index, out_tdata[2:0]);
        check_field("out_x", e.px, out_tdata[34:3]);
        check_field("out_y", e.py, out_tdata[66:35]);
        check_field("normal_x", e.nx, out_tdata[82:67]);
        check_field("normal_y", e.ny, out_tdata[98:83]);
        check_field("center_x", e.cx, out_tdata[130:99]);
        check_field("center_y", e.cy, out_tdata[162:131]);
        check_field("corner_count", e.count, out_tdata[166:163]);
        check_field("final_result", e.last, out_tlast);
      end
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, bit fin);
    if (!calm && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    absorb_vertex(x, y, fin);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (polygon_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_epsilon(logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    epsilon = value;
    @(posedge clk);
  endtask

  task automatic send_polygon(int n, int cenx, int ceny, int rad, bit cw);
    real ang, ph;
    int px, py;
    ph = $urandom_range(628) / 100.0;
    for (int i = 0; i < n; i++) begin
      ang = ph + (cw ? -1.0 : 1.0) * 6.2831853 * i / n;
      px = cenx + $rtoi(rad * $cos(ang));
      py = ceny + $rtoi(rad * $sin(ang));
      send_point(px, py, i == n - 1);
    end
  endtask

  task automatic test_basic_shapes();
    send_point(0, 0, 0);
    send_point(32'h0001_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 0);
    send_point(0, 32'h0001_0000, 1);
    send_polygon(3, 0, 0, 32'h0004_0000, 1);
    send_polygon(8, 32'h0010_0000, -32'h0020_0000, 32'h0100_0000, 0);
  endtask

  task automatic test_counts();
    send_point(5, 6, 1);
    send_point(0, 0, 0);
    send_point(32'h0001_0000, 0, 1);
    for (int i = 0; i < 10; i++) send_point($urandom, $urandom, i == 9);
  endtask

  task automatic test_degenerate();
    send_point(0, 0, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 0);
    send_point(32'h0002_0000, 32'h0002_0000, 1);
    send_point(0, 0, 0);
    send_point(32'h0004_0000, 0, 0);
    send_point(32'h0004_0000, 0, 0);
    send_point(0, 32'h0004_0000, 1);
    send_point(0, 0, 0);
    send_point(32'h0004_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 0);
    send_point(0, 32'h0004_0000, 1);
  endtask

  task automatic test_extremes();
    send_point(32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);
  endtask

  task automatic test_epsilon_settings();
    set_epsilon(32'd0);
    send_polygon(4, 0, 0, 32'h0000_0100, 0);
    test_degenerate();
    set_epsilon(32'hFFFF_FFFF);
    send_polygon(3, 0, 0, 32'h0000_8000, 0);
    send_polygon(5, 0, 0, 32'h0100_0000, 1);
    set_epsilon(32'h0010_0000);
    send_polygon(6, 32'h0100_0000, 0, 32'h0008_0000, 1);
  endtask

  task automatic test_random();
    int sent, n, kind;
    sent = 0;
    while (sent < 50) begin
      calm = (sent >= 10 && sent < 30);
      kind = $urandom_range(99);
      if (kind < 75) begin
        n = $urandom_range(8, 3);
        send_polygon(n, $signed($urandom) >>> 3, $signed($urandom) >>> 3,
                     $urandom_range(32'h1000_0000, 32'h0000_4000), $urandom_range(1));
      end else begin
        n = $urandom_range(11, 1);
        for (int i = 0; i < n; i++) send_point($urandom, $urandom, i == n - 1);
      end
      sent += n;
      if (sent >= 30 && sent - n < 30) begin
        set_epsilon($urandom_range(32'h0001_0000));
      end
    end
    calm = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_shapes();
    test_counts();
    test_degenerate();
    test_extremes();
    test_epsilon_settings();
    set_epsilon(cpb_pkg::EPS_RESET);
    test_random();
    drain();
    if (fails == 0) begin
      $display("convex_polygon_builder_unit verification clean");
    end else begin
      $display("convex_polygon_builder_unit verification failed");
    end
    $finish;
  end

endmodule

/* convex_polygon_builder_unit.f */
rtl/cpb_pkg.sv
rtl/cpb_div.sv
rtl/cpb_isqrt.sv
rtl/cpb_dp.sv
rtl/cpb_ctrl.sv
rtl/convex_polygon_builder_unit.sv
tb/tb_convex_polygon_builder_unit.sv
